// ===== rtl/core/i2cblm_pkg.sv =====
// Shared types and constants for the bit-level I2C master core.
package i2cblm_pkg;

  localparam int unsigned ByteBits = 8;
  localparam int unsigned BitIdxW  = 4;
  localparam int unsigned TickW    = 16;

  // Command codes carried in req_type
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_STOP  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_STOP  = 3'd2,
    PH_WRITE = 3'd3,
    PH_READ  = 3'd4
  } phase_e;

  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] req_type;
    logic [7:0] wr_byte;
    logic       master_nack;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rd_byte;
    logic       slave_nack;
  } out_item_t;

endpackage

// ===== rtl/core/i2c_bit_level_master_core.sv =====
// Bit-level I2C master sequencer: one tick item in, one bus/status item out.
// Latency: an accepted item gives its result item in the output register on the next cycle.
// Throughput: one item per cycle; the bus state and the output register update in one pass.
// A new item is taken while the output register is empty or is being drained.
// Reset: bus idle, SCL/SDA released, no output, read byte/ack cleared, half period 5 ticks.
module i2c_bit_level_master_core
  import i2cblm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [TickW-1:0]       cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  in_item_t               in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output out_item_t              out_item_o
);

  phase_e               phase_q, phase_d;
  logic [BitIdxW-1:0]   bit_idx_q, bit_idx_d;
  logic [ByteBits-1:0]  shift_q, shift_d;
  logic [TickW-1:0]     tick_q, tick_d;
  logic                 nack_q, nack_d;
  logic [ByteBits-1:0]  rd_q, rd_d;
  logic                 ack_q, ack_d;
  logic                 scl_q, scl_d;
  logic                 sda_q, sda_d;
  logic [TickW-1:0]     half_q;
  logic                 out_valid_q;
  out_item_t            out_item_q, out_item_d;
  logic                 in_acc;
  logic [TickW-1:0]     limit;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign limit       = (half_q == '0) ? TickW'(1) : half_q;

  always_comb begin
    phase_d    = phase_q;
    bit_idx_d  = bit_idx_q;
    shift_d    = shift_q;
    tick_d     = tick_q;
    nack_d     = nack_q;
    rd_d       = rd_q;
    ack_d      = ack_q;
    scl_d      = scl_q;
    sda_d      = sda_q;
    out_item_d = '0;

    // Take a new command only while idle
    if (phase_q == PH_IDLE && in_item_i.cmd_valid) begin
      tick_d    = '0;
      bit_idx_d = '0;
      scl_d     = 1'b1;
      case (in_item_i.req_type)
        REQ_START: begin
          phase_d = PH_START;
          sda_d   = 1'b1;
        end
        REQ_STOP: begin
          phase_d = PH_STOP;
          sda_d   = 1'b0;
        end
        REQ_WRITE: begin
          phase_d = PH_WRITE;
          shift_d = in_item_i.wr_byte;
          sda_d   = in_item_i.wr_byte[ByteBits-1];
        end
        default: begin
          phase_d = PH_READ;
          shift_d = '0;
          sda_d   = 1'b1;
          nack_d  = in_item_i.master_nack;
        end
      endcase
    end

    out_item_d.scl_out = scl_d;
    out_item_d.sda_out = sda_d;

    if (phase_d != PH_IDLE) begin
      out_item_d.busy_res = 1'b1;
      tick_d = tick_d + TickW'(1);
      if (tick_d >= limit) begin
        tick_d = '0;
        case (phase_d)
          PH_START: begin
            if (bit_idx_d == '0) begin
              bit_idx_d = BitIdxW'(1);
              sda_d     = 1'b0;
            end else begin
              scl_d               = 1'b0;
              out_item_d.done_res = 1'b1;
            end
          end
          PH_STOP: begin
            if (bit_idx_d == '0) begin
              bit_idx_d = BitIdxW'(1);
              sda_d     = 1'b1;
            end else begin
              out_item_d.done_res = 1'b1;
            end
          end
          PH_WRITE, PH_READ: begin
            if (scl_d) begin
              // End of SCL high: sample the line
              if (phase_d == PH_WRITE) begin
                if (bit_idx_d == BitIdxW'(ByteBits)) ack_d = in_item_i.sda_in;
              end else if (bit_idx_d < BitIdxW'(ByteBits)) begin
                shift_d = {shift_d[ByteBits-2:0], in_item_i.sda_in};
                if (bit_idx_d == BitIdxW'(ByteBits - 1)) rd_d = shift_d;
              end
              scl_d = 1'b0;
            end else begin
              bit_idx_d = bit_idx_d + BitIdxW'(1);
              if (bit_idx_d > BitIdxW'(ByteBits)) begin
                out_item_d.done_res = 1'b1;
              end else begin
                scl_d = 1'b1;
                if (bit_idx_d == BitIdxW'(ByteBits)) begin
                  // Release SDA for the slave's ack, or drive ours on read
                  sda_d = (phase_d == PH_WRITE) ? 1'b1 : nack_d;
                end else if (phase_d == PH_WRITE) begin
                  sda_d = shift_d[3'(ByteBits - 1) - bit_idx_d[2:0]];
                end else begin
                  sda_d = 1'b1;
                end
              end
            end
          end
          default: begin
            out_item_d.done_res = 1'b1;
          end
        endcase
        if (out_item_d.done_res) begin
          phase_d   = PH_IDLE;
          bit_idx_d = '0;
        end
      end
    end

    out_item_d.rd_byte    = rd_d;
    out_item_d.slave_nack = ack_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      bit_idx_q <= '0;
      shift_q   <= '0;
      tick_q    <= '0;
      nack_q    <= 1'b0;
      rd_q      <= '0;
      ack_q     <= 1'b0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
    end else if (in_acc) begin
      phase_q   <= phase_d;
      bit_idx_q <= bit_idx_d;
      shift_q   <= shift_d;
      tick_q    <= tick_d;
      nack_q    <= nack_d;
      rd_q      <= rd_d;
      ack_q     <= ack_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= TickW'(5);
    end else if (cfg_we_i) begin
      half_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_item_q <= out_item_d;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("accepted item produced no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.done_res |-> out_item_q.busy_res)
    else $error("done pulse outside a busy tick");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> tick_q == '0)
    else $error("segment tick counter not cleared while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> bit_idx_q == '0)
    else $error("bit index not cleared while idle");
`endif

endmodule
